// ----- hw/rtl/vtpd_pkg.sv -----
// vtpd_pkg: widths, reset values and register indexes for the vertex
// transform / perspective divide core. No dependencies.
package vtpd_pkg;

    localparam int PT_W    = 32;   // Q16.16 coordinate
    localparam int CF_W    = 16;   // Q4.12 coefficient
    localparam int ROW_W   = 64;   // four coefficients per row
    localparam int PROD_W  = 48;   // coordinate x coefficient
    localparam int H_W     = 50;   // homogeneous sum, signed
    localparam int MAG_W   = 49;   // magnitude of a homogeneous sum
    localparam int NUM_W   = 65;   // dividend: magnitude << 16
    localparam int QB      = 33;   // quotient bits resolved by the divider
    localparam int CFG_IDX_W = 8;

    localparam int XF_STG  = 2;            // products, sums
    localparam int DIV_STG = QB + 2;       // prep, one stage per bit, round
    localparam int NSTG    = XF_STG + DIV_STG;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_B = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_C = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_ROW_D = CFG_IDX_W'(3);

    localparam logic [ROW_W-1:0] ROW_A_RST = 64'h0000_0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_B_RST = 64'h0000_0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_C_RST = 64'h0000_1000_0000_0000;
    localparam logic [ROW_W-1:0] ROW_D_RST = 64'h1000_0000_0000_0000;

    localparam logic [PT_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [PT_W-1:0] OUT_MIN = 32'h8000_0000;
    localparam logic [NUM_W-1:0] RECIP_NUM = NUM_W'(1) << 44;

    typedef logic [3:0][ROW_W-1:0] t_rows;
    typedef logic [3:0][H_W-1:0]   t_hsum;

endpackage

// ----- hw/rtl/vtpd_if.sv -----
// vtpd_if: valid/ready channels for points, results and register writes.
// Depends on vtpd_pkg.
interface vtpd_pt_if import vtpd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface vtpd_res_if import vtpd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] out_x;
    logic signed [PT_W-1:0] out_y;
    logic signed [PT_W-1:0] out_z;
    logic signed [PT_W-1:0] inv_w;
    logic                   w_zero;
    logic                   clipped;
    modport source (output valid, out_x, out_y, out_z, inv_w, w_zero, clipped,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, inv_w, w_zero, clipped,
                    output ready);
endinterface

interface vtpd_cfg_if import vtpd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ROW_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/vtpd_transform.sv -----
// vtpd_transform: point x 4x4 matrix, two stages (products, then sums).
// Depends on vtpd_pkg.
module vtpd_transform import vtpd_pkg::*; (
    input  logic                   i_clk,
    input  logic [1:0]             i_en,
    input  logic signed [PT_W-1:0] i_px,
    input  logic signed [PT_W-1:0] i_py,
    input  logic signed [PT_W-1:0] i_pz,
    input  t_rows                  i_rows,
    output t_hsum                  o_h
);

    logic [3:0][2:0][PROD_W-1:0] r_prod;
    logic [3:0][CF_W-1:0]        r_dcf;
    t_hsum                       r_h;
    logic [2:0][PT_W-1:0]        pt;

    assign pt = {i_pz, i_py, i_px};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < 4; k++) begin
                for (int r = 0; r < 3; r++) begin
                    r_prod[k][r] <= $signed({{(PROD_W-PT_W){pt[r][PT_W-1]}}, pt[r]})
                        * $signed({{(PROD_W-CF_W){i_rows[r][k*CF_W+CF_W-1]}},
                                   i_rows[r][k*CF_W +: CF_W]});
                end
                r_dcf[k] <= i_rows[3][k*CF_W +: CF_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int k = 0; k < 4; k++) begin
                r_h[k] <= {{(H_W-PROD_W){r_prod[k][0][PROD_W-1]}}, r_prod[k][0]}
                        + {{(H_W-PROD_W){r_prod[k][1][PROD_W-1]}}, r_prod[k][1]}
                        + {{(H_W-PROD_W){r_prod[k][2][PROD_W-1]}}, r_prod[k][2]}
                        + {{(H_W-CF_W-16){r_dcf[k][CF_W-1]}}, r_dcf[k], 16'h0000};
            end
        end
    end

    assign o_h = r_h;

endmodule

// ----- hw/rtl/vtpd_div_lane.sv -----
// vtpd_div_lane: pipelined restoring divider, one quotient bit per stage,
// then round-half-away and signed saturation to Q16.16. Depends on vtpd_pkg.
module vtpd_div_lane import vtpd_pkg::*; (
    input  logic               i_clk,
    input  logic [DIV_STG-1:0] i_en,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [MAG_W-1:0]   i_den,
    input  logic               i_neg,
    output logic [PT_W-1:0]    o_val,
    output logic               o_clip
);

    logic [MAG_W-1:0] r_rem [0:QB];
    logic [QB-1:0]    r_nlo [0:QB];
    logic [QB-1:0]    r_q   [0:QB];
    logic [MAG_W-1:0] r_den [0:QB];
    logic             r_neg [0:QB];
    logic             r_ovf [0:QB];
    logic [PT_W-1:0]  r_val;
    logic             r_clip;

    // prep: quotient >= 2^QB means saturation whatever the sign
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= MAG_W'(i_num[NUM_W-1:QB]);
            r_nlo[0] <= i_num[QB-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_ovf[0] <= MAG_W'(i_num[NUM_W-1:QB]) >= i_den;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [MAG_W:0] trial;
        logic           ge;
        logic [MAG_W:0] diff;
        assign trial = {r_rem[j], r_nlo[j][QB-1]};
        assign ge    = trial >= {1'b0, r_den[j]};
        assign diff  = trial - {1'b0, r_den[j]};
        always_ff @(posedge i_clk) begin
            if (i_en[j+1]) begin
                r_rem[j+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                r_nlo[j+1] <= {r_nlo[j][QB-2:0], 1'b0};
                r_q[j+1]   <= {r_q[j][QB-2:0], ge};
                r_den[j+1] <= r_den[j];
                r_neg[j+1] <= r_neg[j];
                r_ovf[j+1] <= r_ovf[j];
            end
        end
    end

    logic          up;
    logic [QB:0]   mag;
    logic [PT_W:0] neg_lim;
    logic          sat;

    assign up      = {r_rem[QB], 1'b0} >= {1'b0, r_den[QB]};
    assign mag     = {1'b0, r_q[QB]} + (QB+1)'(up);
    assign neg_lim = {1'b0, OUT_MIN};
    assign sat     = r_ovf[QB] || (r_neg[QB] ? (mag > (QB+1)'(neg_lim))
                                             : (mag > (QB+1)'(OUT_MAX)));

    always_ff @(posedge i_clk) begin
        if (i_en[DIV_STG-1]) begin
            r_clip <= sat;
            if (r_neg[QB]) begin
                r_val <= sat ? OUT_MIN : PT_W'(-mag);
            end else begin
                r_val <= sat ? OUT_MAX : mag[PT_W-1:0];
            end
        end
    end

    assign o_val  = r_val;
    assign o_clip = r_clip;

endmodule

// ----- hw/rtl/vertex_transform_perspective_divide_core.sv -----
// Vertex transform with perspective divide: top level, matrix registers,
// stage handshake. Depends on vtpd_pkg, vtpd_if, vtpd_transform, vtpd_div_lane.
//
//  channel  | dir | word                                        | accepted when
//  i_pt     | in  | point_x, point_y, point_z                   | valid && ready
//  o_res    | out | out_x, out_y, out_z, inv_w, w_zero, clipped | valid && ready
//  i_cfg    | in  | index, data (rows a..d at index 0..3)       | valid && ready
//
// One point per cycle while o_res is ready. Stages: two transform, a divider
// prep, one per quotient bit (33) and a round/saturate stage.
// Synchronous active-low reset empties the pipe and loads the identity matrix.
// Each stage holds when it is full and the stage after it cannot take its
// word, so bubbles close up and a stalled output still lets points enter.
module vertex_transform_perspective_divide_core import vtpd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vtpd_pt_if.sink      i_pt,
    vtpd_res_if.source   o_res,
    vtpd_cfg_if.sink     i_cfg
);

    t_rows r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= {ROW_D_RST, ROW_C_RST, ROW_B_RST, ROW_A_RST};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ROW_A: r_rows[0] <= i_cfg.data;
                REG_ROW_B: r_rows[1] <= i_cfg.data;
                REG_ROW_C: r_rows[2] <= i_cfg.data;
                REG_ROW_D: r_rows[3] <= i_cfg.data;
                default: ;
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    // stage enables: a stage loads when empty or when its successor moves
    logic [NSTG-1:0] r_vld;
    logic [NSTG:0]   en;
    assign en[NSTG] = o_res.ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_en
        assign en[k] = !r_vld[k] || en[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pt.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    t_hsum h;
    vtpd_transform u_xf (
        .i_clk  (i_clk),
        .i_en   (en[XF_STG-1:0]),
        .i_px   (i_pt.point_x),
        .i_py   (i_pt.point_y),
        .i_pz   (i_pt.point_z),
        .i_rows (r_rows),
        .o_h    (h)
    );

    // w-zero flag rides alongside the divider stages
    logic r_wz [0:DIV_STG-1];
    always_ff @(posedge i_clk) begin
        if (en[XF_STG]) begin
            r_wz[0] <= (h[3] == '0);
        end
        for (int k = 1; k < DIV_STG; k++) begin
            if (en[XF_STG+k]) begin
                r_wz[k] <= r_wz[k-1];
            end
        end
    end

    logic [MAG_W-1:0] mag [0:3];
    for (genvar k = 0; k < 4; k++) begin : g_mag
        logic [H_W-1:0] neg_h;
        assign neg_h  = -h[k];
        assign mag[k] = h[k][H_W-1] ? neg_h[MAG_W-1:0] : h[k][MAG_W-1:0];
    end

    logic [PT_W-1:0] val  [0:3];
    logic            clip [0:3];
    for (genvar k = 0; k < 4; k++) begin : g_lane
        logic [NUM_W-1:0] num;
        logic             neg;
        if (k == 3) begin : g_recip
            assign num = RECIP_NUM;
            assign neg = h[3][H_W-1];
        end else begin : g_coord
            assign num = {mag[k], 16'h0000};
            assign neg = (h[k] != '0) && (h[k][H_W-1] != h[3][H_W-1]);
        end
        vtpd_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (en[NSTG-1:XF_STG]),
            .i_num  (num),
            .i_den  (mag[3]),
            .i_neg  (neg),
            .o_val  (val[k]),
            .o_clip (clip[k])
        );
    end

    logic wz;
    assign wz = r_wz[DIV_STG-1];

    assign i_pt.ready    = en[0];
    assign o_res.valid   = r_vld[NSTG-1];
    assign o_res.out_x   = wz ? '0 : val[0];
    assign o_res.out_y   = wz ? '0 : val[1];
    assign o_res.out_z   = wz ? '0 : val[2];
    assign o_res.inv_w   = wz ? '0 : val[3];
    assign o_res.w_zero  = wz;
    assign o_res.clipped = !wz && (clip[0] || clip[1] || clip[2] || clip[3]);

    a_wz_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.w_zero |-> !o_res.clipped && o_res.inv_w == '0
            && o_res.out_x == '0)
        else $error("w_zero result carries nonzero data");

    a_empty_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_pt.ready)
        else $error("input stalled with an empty output stage");

    a_drain_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.ready |-> i_pt.ready)
        else $error("input stalled while the output drains");

    a_clip_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.clipped |->
            o_res.out_x == OUT_MAX || o_res.out_x == OUT_MIN ||
            o_res.out_y == OUT_MAX || o_res.out_y == OUT_MIN ||
            o_res.out_z == OUT_MAX || o_res.out_z == OUT_MIN ||
            o_res.inv_w == OUT_MAX || o_res.inv_w == OUT_MIN)
        else $error("clipped set with no value at a limit");

endmodule
